// ===== design/dtss_pkg.sv =====
// Shared types and constants for the track sector search block.
package dtss_pkg;

	// Default width of the track position counter.
	localparam int POSITION_BITS_DEF = 24;

	// Field widths.
	localparam int AVAIL_W    = 24;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Sector header layout.
	localparam int HDR_IDX_W = 4;
	localparam logic [HDR_IDX_W-1:0] HDR_CYLINDER  = 4'd0;
	localparam logic [HDR_IDX_W-1:0] HDR_HEAD      = 4'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_RECORD    = 4'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_SIZE_CODE = 4'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_COUNT_LO  = 4'd4;
	localparam logic [HDR_IDX_W-1:0] HDR_COUNT_HI  = 4'd5;
	localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO    = 4'h0e;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST      = 4'hf;
	localparam logic [COUNT_W-1:0]   HDR_LEN       = 16'd16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WANT_CYLINDER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_HEAD       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_RECORD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_SIZE_CODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AVAILABLE_BYTES = 3'd5;

	// Result outcome codes.
	localparam logic [1:0] OUT_DATA      = 2'd0;
	localparam logic [1:0] OUT_LAST      = 2'd1;
	localparam logic [1:0] OUT_EMPTY     = 2'd2;
	localparam logic [1:0] OUT_NOT_FOUND = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_SKIP   = 5'b00100,
		PH_COPY   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

endpackage

// ===== design/disk_track_sector_search.sv =====
// A result beat appears in the output register in the cycle after its track byte is taken.
// Throughput: one track byte per cycle unless a held result stalls in_ready; the output
// register is refilled while it is being taken. The per-byte header parse, room checks and
// copy count are combinational. Reset (arst_n low) clears the scan state to idle and loads
// the register defaults (want_record 1, all others 0); no clearing pass is needed.
module disk_track_sector_search #(
	parameter int POSITION_BITS = dtss_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dtss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      track_byte,
	input  logic                            first,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      data_byte,
	output logic [1:0]                      outcome,
	output logic [dtss_pkg::COUNT_W-1:0]    copied_count
);

	localparam int CW = dtss_pkg::COUNT_W;
	localparam int AW = dtss_pkg::AVAIL_W;
	localparam int HW = dtss_pkg::HDR_IDX_W;
	localparam int RW = (POSITION_BITS > AW) ? POSITION_BITS : AW;

	// Configuration registers.
	logic [7:0]    want_cylinder_q, want_head_q, want_record_q, want_size_code_q;
	logic [CW-1:0] max_bytes_q;
	logic [AW-1:0] available_q;

	// Scan state.
	dtss_pkg::phase_t   phase_q, phase_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, pos_inc;
	logic [HW-1:0] idx_q, idx_d;
	logic [7:0]    cyl_q, cyl_d, head_q, head_d, rec_q, rec_d, size_q, size_d;
	logic [CW-1:0] sec_cnt_q, sec_cnt_d;
	logic [7:0]    len_lo_q, len_lo_d;
	logic [CW-1:0] left_q, left_d, left_dec;
	logic [CW-1:0] cnt_q, cnt_d, cnt_inc;

	// Result register.
	logic          out_valid_q;
	logic [7:0]    data_q;
	logic [1:0]    outcome_q;
	logic [CW-1:0] count_q;

	logic          emit;
	logic [7:0]    emit_data;
	logic [1:0]    emit_code;
	logic [CW-1:0] emit_count;

	logic          in_fire;
	logic [CW-1:0] hdr_len, copy_len;
	logic [RW-1:0] avail_ext, pos_chk, room;
	logic          pos_fits, room_len_ok, room_hdr_ok, id_match;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	assign out_valid    = out_valid_q;
	assign data_byte    = data_q;
	assign outcome      = outcome_q;
	assign copied_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_cylinder_q  <= '0;
			want_head_q      <= '0;
			want_record_q    <= 8'd1;
			want_size_code_q <= '0;
			max_bytes_q      <= '0;
			available_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dtss_pkg::REG_WANT_CYLINDER:   want_cylinder_q  <= cfg_data[7:0];
				dtss_pkg::REG_WANT_HEAD:       want_head_q      <= cfg_data[7:0];
				dtss_pkg::REG_WANT_RECORD:     want_record_q    <= cfg_data[7:0];
				dtss_pkg::REG_WANT_SIZE_CODE:  want_size_code_q <= cfg_data[7:0];
				dtss_pkg::REG_MAX_BYTES:       max_bytes_q      <= cfg_data[CW-1:0];
				dtss_pkg::REG_AVAILABLE_BYTES: available_q      <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	assign pos_inc  = pos_q + 1'b1;
	assign left_dec = left_q - 1'b1;
	assign cnt_inc  = cnt_q + 1'b1;
	assign hdr_len  = {track_byte, len_lo_q};
	assign copy_len = (hdr_len < max_bytes_q) ? hdr_len : max_bytes_q;

	// Room checks look at the position after this byte; a new track starts at zero.
	assign avail_ext   = RW'(available_q);
	assign pos_chk     = first ? '0 : RW'(pos_inc);
	assign pos_fits    = pos_chk <= avail_ext;
	assign room        = avail_ext - pos_chk;
	assign room_hdr_ok = pos_fits && (room >= RW'(dtss_pkg::HDR_LEN));
	assign room_len_ok = pos_fits && (room >= RW'(hdr_len));
	assign id_match    = (cyl_q == want_cylinder_q) && (head_q == want_head_q) &&
		(rec_q == want_record_q) && (size_q == want_size_code_q);

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		idx_d      = idx_q;
		cyl_d      = cyl_q;
		head_d     = head_q;
		rec_d      = rec_q;
		size_d     = size_q;
		sec_cnt_d  = sec_cnt_q;
		len_lo_d   = len_lo_q;
		left_d     = left_q;
		cnt_d      = cnt_q;
		emit       = 1'b0;
		emit_data  = '0;
		emit_code  = dtss_pkg::OUT_NOT_FOUND;
		emit_count = '0;
		if (first) begin
			pos_d     = '0;
			idx_d     = '0;
			sec_cnt_d = '0;
			len_lo_d  = '0;
			left_d    = '0;
			cnt_d     = '0;
			if (!room_hdr_ok) begin
				phase_d = dtss_pkg::PH_DONE;
				emit    = 1'b1;
			end else begin
				// The byte is the cylinder of the first header.
				phase_d = dtss_pkg::PH_HEADER;
				cyl_d   = track_byte;
				pos_d   = POSITION_BITS'(1);
				idx_d   = HW'(1);
			end
		end else begin
			case (phase_q)
				dtss_pkg::PH_HEADER: begin
					pos_d = pos_inc;
					idx_d = idx_q + 1'b1;
					case (idx_q)
						dtss_pkg::HDR_CYLINDER:  cyl_d  = track_byte;
						dtss_pkg::HDR_HEAD:      head_d = track_byte;
						dtss_pkg::HDR_RECORD:    rec_d  = track_byte;
						dtss_pkg::HDR_SIZE_CODE: size_d = track_byte;
						dtss_pkg::HDR_COUNT_LO:  sec_cnt_d[7:0]  = track_byte;
						dtss_pkg::HDR_COUNT_HI:  sec_cnt_d[15:8] = track_byte;
						dtss_pkg::HDR_LEN_LO:    len_lo_d = track_byte;
						default: ;
					endcase
					if (idx_q == dtss_pkg::HDR_LAST) begin
						if (sec_cnt_q == '0 || !room_len_ok) begin
							phase_d = dtss_pkg::PH_DONE;
							emit    = 1'b1;
						end else if (id_match) begin
							cnt_d = '0;
							if (copy_len == '0) begin
								phase_d   = dtss_pkg::PH_DONE;
								emit      = 1'b1;
								emit_code = dtss_pkg::OUT_EMPTY;
							end else begin
								left_d  = copy_len;
								phase_d = dtss_pkg::PH_COPY;
							end
						end else if (hdr_len == '0) begin
							// An empty entry: the next header follows at once.
							if (!room_hdr_ok) begin
								phase_d = dtss_pkg::PH_DONE;
								emit    = 1'b1;
							end
						end else begin
							left_d  = hdr_len;
							phase_d = dtss_pkg::PH_SKIP;
						end
					end
				end
				dtss_pkg::PH_SKIP: begin
					pos_d  = pos_inc;
					left_d = left_dec;
					if (left_dec == '0) begin
						if (!room_hdr_ok) begin
							phase_d = dtss_pkg::PH_DONE;
							emit    = 1'b1;
						end else begin
							phase_d = dtss_pkg::PH_HEADER;
							idx_d   = '0;
						end
					end
				end
				dtss_pkg::PH_COPY: begin
					pos_d      = pos_inc;
					cnt_d      = cnt_inc;
					left_d     = left_dec;
					emit       = 1'b1;
					emit_data  = track_byte;
					emit_count = cnt_inc;
					emit_code  = dtss_pkg::OUT_DATA;
					if (left_dec == '0) begin
						phase_d   = dtss_pkg::PH_DONE;
						emit_code = dtss_pkg::OUT_LAST;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= dtss_pkg::PH_IDLE;
			pos_q     <= '0;
			idx_q     <= '0;
			cyl_q     <= '0;
			head_q    <= '0;
			rec_q     <= '0;
			size_q    <= '0;
			sec_cnt_q <= '0;
			len_lo_q  <= '0;
			left_q    <= '0;
			cnt_q     <= '0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			idx_q     <= idx_d;
			cyl_q     <= cyl_d;
			head_q    <= head_d;
			rec_q     <= rec_d;
			size_q    <= size_d;
			sec_cnt_q <= sec_cnt_d;
			len_lo_q  <= len_lo_d;
			left_q    <= left_d;
			cnt_q     <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			data_q    <= emit_data;
			outcome_q <= emit_code;
			count_q   <= emit_count;
		end
	end

endmodule
